/* rtl/core/e2u_pkg.sv */
// Shared types and constants for the escaped-string to UTF-8 decoder.
`default_nettype none

package e2u_pkg;

  // Byte codes of the escape syntax
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_UC_X   = 8'h58;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_U   = 8'h55;

  // Control codes produced by letter escapes
  localparam logic [7:0] CC_LF = 8'h0A;
  localparam logic [7:0] CC_CR = 8'h0D;
  localparam logic [7:0] CC_HT = 8'h09;
  localparam logic [7:0] CC_FF = 8'h0C;
  localparam logic [7:0] CC_VT = 8'h0B;

  // Hex digit limits per escape letter
  localparam logic [3:0] HEX_LEN_X  = 4'd2;
  localparam logic [3:0] HEX_LEN_U4 = 4'd4;
  localparam logic [3:0] HEX_LEN_U8 = 4'd8;

  // UTF-8 lead and continuation markers
  localparam logic [7:0] U8_CONT  = 8'h80;
  localparam logic [7:0] U8_LEAD2 = 8'hC0;
  localparam logic [7:0] U8_LEAD3 = 8'hE0;
  localparam logic [7:0] U8_LEAD4 = 8'hF0;
  localparam logic [7:0] U8_LEAD5 = 8'hF8;
  localparam logic [7:0] U8_LEAD6 = 8'hFC;

  // Code point range bounds for each encoded length
  localparam logic [31:0] U8_LIM1 = 32'h0000_0080;
  localparam logic [31:0] U8_LIM2 = 32'h0000_0800;
  localparam logic [31:0] U8_LIM3 = 32'h0001_0000;
  localparam logic [31:0] U8_LIM4 = 32'h0020_0000;
  localparam logic [31:0] U8_LIM5 = 32'h0400_0000;

  // Encoded code point: up to six bytes, first byte in slot 0
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  // All output bytes caused by one input transaction, first in slot 0
  typedef struct packed {
    logic [6:0][7:0] bytes;
    logic [2:0]      cnt;
  } run_t;

endpackage

`default_nettype wire

/* rtl/core/e2u_utf8_enc.sv */
// UTF-8 encoder for one 32-bit code point, 1 to 6 bytes.
`default_nettype none

module e2u_utf8_enc
  import e2u_pkg::*;
(
  input  wire logic [31:0] code,
  output utf8_t            enc
);

  // Pick the length by range, then slice six-bit groups
  always_comb begin
    enc.bytes = '0;
    if (code < U8_LIM1) begin
      enc.len      = 3'd1;
      enc.bytes[0] = code[7:0];
    end else if (code < U8_LIM2) begin
      enc.len      = 3'd2;
      enc.bytes[0] = U8_LEAD2 | {3'b000, code[10:6]};
      enc.bytes[1] = U8_CONT  | {2'b00, code[5:0]};
    end else if (code < U8_LIM3) begin
      enc.len      = 3'd3;
      enc.bytes[0] = U8_LEAD3 | {4'b0000, code[15:12]};
      enc.bytes[1] = U8_CONT  | {2'b00, code[11:6]};
      enc.bytes[2] = U8_CONT  | {2'b00, code[5:0]};
    end else if (code < U8_LIM4) begin
      enc.len      = 3'd4;
      enc.bytes[0] = U8_LEAD4 | {5'b00000, code[20:18]};
      enc.bytes[1] = U8_CONT  | {2'b00, code[17:12]};
      enc.bytes[2] = U8_CONT  | {2'b00, code[11:6]};
      enc.bytes[3] = U8_CONT  | {2'b00, code[5:0]};
    end else if (code < U8_LIM5) begin
      enc.len      = 3'd5;
      enc.bytes[0] = U8_LEAD5 | {6'b000000, code[25:24]};
      enc.bytes[1] = U8_CONT  | {2'b00, code[23:18]};
      enc.bytes[2] = U8_CONT  | {2'b00, code[17:12]};
      enc.bytes[3] = U8_CONT  | {2'b00, code[11:6]};
      enc.bytes[4] = U8_CONT  | {2'b00, code[5:0]};
    end else begin
      enc.len      = 3'd6;
      enc.bytes[0] = U8_LEAD6 | {6'b000000, code[31:30]};
      enc.bytes[1] = U8_CONT  | {2'b00, code[29:24]};
      enc.bytes[2] = U8_CONT  | {2'b00, code[23:18]};
      enc.bytes[3] = U8_CONT  | {2'b00, code[17:12]};
      enc.bytes[4] = U8_CONT  | {2'b00, code[11:6]};
      enc.bytes[5] = U8_CONT  | {2'b00, code[5:0]};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/e2u_decode.sv */
// Escape parser: phase and code point state, builds the output run per byte.
`default_nettype none

module e2u_decode
  import e2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eos,
  output run_t            run
);

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_OCT  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  left_r, left_nxt;

  logic        is_oct, is_hex;
  logic [3:0]  hex_val;
  logic [3:0]  left_dec;
  logic        flush;
  logic [31:0] flush_val;
  logic        tail_en;
  logic [7:0]  tail;
  logic [2:0]  flen;
  logic [6:0][7:0] enc7;
  utf8_t       enc;

  // Classify the incoming byte as an octal or hex digit
  always_comb begin
    is_oct  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    is_hex  = 1'b1;
    hex_val = 4'd0;
    priority if ((in_byte >= CH_ZERO) && (in_byte <= CH_NINE)) begin
      hex_val = 4'(in_byte - CH_ZERO);
    end else if ((in_byte >= CH_UC_A) && (in_byte <= CH_UC_F)) begin
      hex_val = 4'(in_byte - CH_UC_A + 8'd10);
    end else if ((in_byte >= CH_LC_A) && (in_byte <= CH_LC_F)) begin
      hex_val = 4'(in_byte - CH_LC_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign left_dec = left_r - 4'd1;

  // Next state, optional code point flush and optional trailing byte
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    flush     = 1'b0;
    flush_val = acc_r;
    tail_en   = 1'b0;
    tail      = in_byte;
    unique case (phase_r)
      PH_TEXT: begin
        if (in_byte == CH_BSLASH) begin
          phase_nxt = in_eos ? PH_TEXT : PH_ESC;
        end else begin
          tail_en = 1'b1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_TEXT;
        unique case (in_byte)
          CH_LC_N: begin tail_en = 1'b1; tail = CC_LF; end
          CH_LC_R: begin tail_en = 1'b1; tail = CC_CR; end
          CH_LC_T: begin tail_en = 1'b1; tail = CC_HT; end
          CH_LC_F: begin tail_en = 1'b1; tail = CC_FF; end
          CH_LC_V: begin tail_en = 1'b1; tail = CC_VT; end
          CH_LC_X, CH_UC_X, CH_LC_U, CH_UC_U: begin
            acc_nxt   = '0;
            left_nxt  = (in_byte == CH_UC_U) ? HEX_LEN_U8 :
                        (in_byte == CH_LC_U) ? HEX_LEN_U4 : HEX_LEN_X;
            phase_nxt = PH_HEX;
            flush     = in_eos;
            flush_val = '0;
          end
          default: begin
            if (is_oct) begin
              acc_nxt   = {29'd0, in_byte[2:0]};
              phase_nxt = PH_OCT;
              flush     = in_eos;
              flush_val = {29'd0, in_byte[2:0]};
            end else begin
              tail_en = 1'b1;
            end
          end
        endcase
      end
      PH_OCT: begin
        if (is_oct) begin
          acc_nxt   = {acc_r[28:0], in_byte[2:0]};
          flush     = in_eos;
          flush_val = {acc_r[28:0], in_byte[2:0]};
        end else begin
          flush     = 1'b1;
          flush_val = acc_r;
          tail_en   = (in_byte != CH_BSLASH);
        end
      end
      PH_HEX: begin
        if (is_hex) begin
          acc_nxt   = {acc_r[27:0], hex_val};
          left_nxt  = left_dec;
          flush     = (left_dec == 4'd0) || in_eos;
          flush_val = {acc_r[27:0], hex_val};
        end else begin
          flush     = 1'b1;
          flush_val = acc_r;
          tail_en   = (in_byte != CH_BSLASH);
        end
      end
      default: begin
        phase_nxt = PH_TEXT;
      end
    endcase

    // A flush clears the code point state; a backslash ending a run opens an escape
    if (flush) begin
      acc_nxt   = '0;
      left_nxt  = '0;
      phase_nxt = PH_TEXT;
      if (((phase_r == PH_OCT) && !is_oct) || ((phase_r == PH_HEX) && !is_hex)) begin
        if ((in_byte == CH_BSLASH) && !in_eos) begin
          phase_nxt = PH_ESC;
        end
      end
    end
  end

  e2u_utf8_enc u_enc (
    .code (flush_val),
    .enc  (enc)
  );

  // Place the encoded bytes first, then the trailing byte
  always_comb begin
    flen = flush ? enc.len : 3'd0;
    enc7 = {8'h00, enc.bytes};
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < flen) begin
        run.bytes[i] = enc7[i];
      end else if ((3'(i) == flen) && tail_en) begin
        run.bytes[i] = tail;
      end else begin
        run.bytes[i] = 8'h00;
      end
    end
    run.cnt = flen + {2'b00, tail_en};
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      acc_r   <= '0;
      left_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/e2u_emit.sv */
// Result register and byte serializer for one transaction's output run.
`default_nettype none

module e2u_emit
  import e2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire run_t       run,
  output logic            take_ok,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  logic [6:0][7:0] buf_r, buf_nxt;
  logic [2:0]      rem_r, rem_nxt;
  logic            out_fire;
  logic            load;

  assign out_fire   = out_tvalid && out_tready;
  assign out_tvalid = (rem_r != 3'd0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = (rem_r == 3'd1);
  // Accept a new run when empty or when the last byte leaves this cycle
  assign take_ok    = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_tready);
  assign load       = in_fire && (run.cnt != 3'd0);

  // Load a fresh run, or shift out one byte
  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (load) begin
      buf_nxt = run.bytes;
      rem_nxt = run.cnt;
    end else if (out_fire) begin
      buf_nxt = {8'h00, buf_r[6:1]};
      rem_nxt = rem_r - 3'd1;
    end else if (in_fire) begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/escape_to_utf8_decoder.sv */
// Top level of the escaped-string to UTF-8 decoder.
// First output byte of a transaction: registered, valid in the cycle after it is accepted.
// Throughput: one input transaction per cycle while each yields at most one byte and
// the output is not stalled. A transaction yielding k bytes (up to 7) holds in_tready
// low until its last byte leaves the serializer, which sends one byte per unstalled cycle.
// Reset: synchronous, active low; returns to plain text with an empty output register.
`default_nettype none

module escape_to_utf8_decoder
  import e2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // end_of_string
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // run_last
);

  logic in_fire;
  run_t run;

  assign in_fire = in_tvalid && in_tready;

  e2u_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_eos  (in_tlast),
    .run     (run)
  );

  e2u_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .run        (run),
    .take_ok    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* rtl/core/e2u_checker.sv */
// Port-level checks for the decoder, bound to the top level.
`default_nettype none

module e2u_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // Drop output valid after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Stall input only while a result is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending output");

  // Send the rest of a run without gaps; input stays held until its last byte
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && (out_tlast || !in_tready))
    else $error("output run broken");

endmodule

bind escape_to_utf8_decoder e2u_checker u_e2u_checker (.*);

`default_nettype wire

/* tb/escape_to_utf8_decoder_tb.sv */
// Self-checking testbench for the escaped-string to UTF-8 decoder.
`timescale 1ns / 1ps

module escape_to_utf8_decoder_tb;
  import e2u_pkg::*;

  // Decoder phase, tracked by the prediction
  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_OCT,
    PH_HEX
  } dec_phase_e;

  // One input transaction; typed rows carry their expected bytes, first in want[7:0]
  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [2:0]  nres;
    logic [15:0] want;
  } stim_row_t;

  // One expected output transaction
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } dec_byte_t;

  localparam int RAND_ITEMS   = 284;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 36;

  // Directed rows: extremes, letter escapes, unknown escape, empty hex run,
  // full-width hex run, flush at end of string, trailing backslash
  localparam stim_row_t DIR_TAB [26] = '{
    '{8'h00,     1'b0, 1'b1, 3'd1, 16'h0000},
    '{8'hFF,     1'b0, 1'b1, 3'd1, 16'h00FF},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_LC_N,   1'b0, 1'b1, 3'd1, {8'h00, CC_LF}},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_LC_R,   1'b0, 1'b1, 3'd1, {8'h00, CC_CR}},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{8'h71,     1'b0, 1'b1, 3'd1, 16'h0071},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_UC_X,   1'b0, 1'b1, 3'd0, 16'h0000},
    '{8'h67,     1'b0, 1'b1, 3'd2, 16'h6700},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_UC_U,   1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_UC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_LC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_UC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_LC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_UC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_LC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_UC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_LC_F,   1'b0, 1'b0, 3'd0, 16'h0000},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_SEVEN,  1'b1, 1'b1, 3'd1, 16'h0007},
    '{CH_BSLASH, 1'b1, 1'b1, 3'd0, 16'h0000},
    '{CH_BSLASH, 1'b0, 1'b1, 3'd0, 16'h0000},
    '{CH_LC_V,   1'b0, 1'b1, 3'd1, {8'h00, CC_VT}}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  stim_row_t  stim_q [$];
  logic [7:0] pending [$];
  dec_byte_t  decoded_q [$];

  dec_phase_e  dec_phase = PH_TEXT;
  logic [31:0] dec_code  = '0;
  logic [3:0]  dec_left  = '0;

  int  acc_idx     = 0;
  int  bytes_out   = 0;
  int  fail_count  = 0;
  int  stall_count = 0;
  bit  held_off    = 1'b0;

  escape_to_utf8_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Hex digit value in [3:0], valid flag in [4]
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= CH_ZERO && b <= CH_NINE) return {1'b1, b[3:0]};
    if (b >= CH_UC_A && b <= CH_UC_F) v = b - CH_UC_A + 8'd10;
    else if (b >= CH_LC_A && b <= CH_LC_F) v = b - CH_LC_A + 8'd10;
    else return 5'd0;
    return {1'b1, v[3:0]};
  endfunction

  function automatic logic [7:0] cont_byte(input logic [5:0] bits6);
    return U8_CONT | {2'b00, bits6};
  endfunction

  // Encode a code point as 1 to 6 UTF-8 bytes
  function automatic void encode_utf8(input logic [31:0] c);
    if (c < U8_LIM1) begin
      pending.push_back(c[7:0]);
    end else if (c < U8_LIM2) begin
      pending.push_back(U8_LEAD2 | {3'b000, c[10:6]});
      pending.push_back(cont_byte(c[5:0]));
    end else if (c < U8_LIM3) begin
      pending.push_back(U8_LEAD3 | {4'b0000, c[15:12]});
      pending.push_back(cont_byte(c[11:6]));
      pending.push_back(cont_byte(c[5:0]));
    end else if (c < U8_LIM4) begin
      pending.push_back(U8_LEAD4 | {5'b00000, c[20:18]});
      pending.push_back(cont_byte(c[17:12]));
      pending.push_back(cont_byte(c[11:6]));
      pending.push_back(cont_byte(c[5:0]));
    end else if (c < U8_LIM5) begin
      pending.push_back(U8_LEAD5 | {6'b000000, c[25:24]});
      pending.push_back(cont_byte(c[23:18]));
      pending.push_back(cont_byte(c[17:12]));
      pending.push_back(cont_byte(c[11:6]));
      pending.push_back(cont_byte(c[5:0]));
    end else begin
      pending.push_back(U8_LEAD6 | {6'b000000, c[31:30]});
      pending.push_back(cont_byte(c[29:24]));
      pending.push_back(cont_byte(c[23:18]));
      pending.push_back(cont_byte(c[17:12]));
      pending.push_back(cont_byte(c[11:6]));
      pending.push_back(cont_byte(c[5:0]));
    end
  endfunction

  function automatic void flush_code_point();
    encode_utf8(dec_code);
    dec_phase = PH_TEXT;
    dec_code  = '0;
    dec_left  = '0;
  endfunction

  function automatic void text_byte(input logic [7:0] b, input logic eos);
    if (b == CH_BSLASH) dec_phase = eos ? PH_TEXT : PH_ESC;
    else pending.push_back(b);
  endfunction

  // Advance the decoder state by one source byte; decoded bytes land in pending
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    logic [4:0] hv;
    logic       is_oct;
    hv     = hex_nibble(b);
    is_oct = (b >= CH_ZERO && b <= CH_SEVEN);
    case (dec_phase)
      PH_TEXT: text_byte(b, eos);
      PH_ESC: begin
        dec_phase = PH_TEXT;
        case (b)
          CH_LC_N: pending.push_back(CC_LF);
          CH_LC_R: pending.push_back(CC_CR);
          CH_LC_T: pending.push_back(CC_HT);
          CH_LC_F: pending.push_back(CC_FF);
          CH_LC_V: pending.push_back(CC_VT);
          CH_LC_X, CH_UC_X, CH_LC_U, CH_UC_U: begin
            dec_code  = '0;
            dec_left  = (b == CH_UC_U) ? HEX_LEN_U8 : (b == CH_LC_U) ? HEX_LEN_U4 : HEX_LEN_X;
            dec_phase = PH_HEX;
            if (eos) flush_code_point();
          end
          default: begin
            if (is_oct) begin
              dec_code  = {29'd0, b[2:0]};
              dec_phase = PH_OCT;
              if (eos) flush_code_point();
            end else begin
              pending.push_back(b);
            end
          end
        endcase
      end
      PH_OCT: begin
        if (is_oct) begin
          dec_code = {dec_code[28:0], b[2:0]};
          if (eos) flush_code_point();
        end else begin
          flush_code_point();
          text_byte(b, eos);
        end
      end
      default: begin
        if (hv[4]) begin
          dec_code = {dec_code[27:0], hv[3:0]};
          dec_left = dec_left - 4'd1;
          if (dec_left == 4'd0 || eos) flush_code_point();
        end else begin
          flush_code_point();
          text_byte(b, eos);
        end
      end
    endcase
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic eos);
    stim_q.push_back('{b, eos, 1'b0, 3'd0, 16'h0000});
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return (chance(50) ? CH_UC_A : CH_LC_A) + 8'(v - 10);
  endfunction

  // Mostly well-formed escape sequences with random content, some noise
  task automatic build_random();
    int          first;
    int          r;
    int          ndig;
    int          lead0;
    int          lim;
    logic [7:0]  ch;
    first = stim_q.size();
    while (stim_q.size() - first < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 20) begin
        repeat ($urandom_range(1, 4)) begin
          ch = 8'($urandom_range(255));
          if (ch == CH_BSLASH) ch = 8'h2F;
          add_item(ch, chance(4));
        end
      end else if (r < 35) begin
        add_item(CH_BSLASH, 1'b0);
        case ($urandom_range(4))
          0: ch = CH_LC_N;
          1: ch = CH_LC_R;
          2: ch = CH_LC_T;
          3: ch = CH_LC_F;
          default: ch = CH_LC_V;
        endcase
        add_item(ch, chance(8));
      end else if (r < 43) begin
        add_item(CH_BSLASH, chance(3));
        add_item(8'($urandom_range(255)), chance(8));
      end else if (r < 70) begin
        add_item(CH_BSLASH, 1'b0);
        case ($urandom_range(3))
          0: begin ch = CH_LC_X; lim = 2; end
          1: begin ch = CH_UC_X; lim = 2; end
          2: begin ch = CH_LC_U; lim = 4; end
          default: begin ch = CH_UC_U; lim = 8; end
        endcase
        add_item(ch, chance(3));
        ndig  = chance(65) ? lim : $urandom_range(0, lim);
        if (chance(15)) ndig = ndig + $urandom_range(1, 2);
        lead0 = $urandom_range(0, lim - 1);
        for (int k = 0; k < ndig; k++) begin
          add_item(hex_char((k < lead0) ? 0 : $urandom_range(15)), chance(3));
        end
        if (chance(60)) add_item(8'($urandom_range(255)), chance(8));
      end else if (r < 88) begin
        add_item(CH_BSLASH, 1'b0);
        ndig = $urandom_range(1, 12);
        for (int k = 0; k < ndig; k++) begin
          add_item(CH_ZERO + 8'($urandom_range(7)), chance(3));
        end
        if (chance(70)) add_item(8'($urandom_range(255)), chance(8));
      end else begin
        repeat ($urandom_range(1, 3)) add_item(8'($urandom_range(255)), chance(10));
      end
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    int idx;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
    build_random();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idx = 0;
    while (idx < stim_q.size()) begin
      if (!(idx >= 150 && idx < 230) && chance(IDLE_PCT)) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= stim_q[idx].data;
        in_tlast  <= stim_q[idx].eos;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        idx++;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, a quiet stretch
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && bytes_out >= 120) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= (bytes_out >= 300 && bytes_out < 420) ? 1'b1 : !chance(IDLE_PCT);
      end
    end
  end

  // Predict on each input transaction, check each output transaction
  always @(posedge clk) begin : monitor
    dec_byte_t want;
    if (rst_n && in_tvalid && in_tready) begin
      pending.delete();
      decode_byte(in_tdata, in_tlast);
      if (stim_q[acc_idx].typed) begin
        pending.delete();
        for (int k = 0; k < stim_q[acc_idx].nres; k++) begin
          pending.push_back(stim_q[acc_idx].want[8*k +: 8]);
        end
      end
      foreach (pending[k]) decoded_q.push_back('{pending[k], k == pending.size() - 1});
      acc_idx++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      bytes_out++;
      if (decoded_q.size() == 0) begin
        $error("out_byte %02h arrived with no expected byte pending", out_tdata);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.b) begin
          $error("out_byte mismatch: expected %02h, actual %02h", want.b, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("run_last mismatch: expected %0b, actual %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
